// File: src/llp_pkg.sv
// shared symbol codes, status codes, types and prediction tables of the ll(1) parser
`default_nettype none

package llp_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int HW          = $clog2(STACK_DEPTH + 1);
    localparam int AW          = $clog2(STACK_DEPTH);

    typedef logic [4:0]      t_sym;
    typedef logic [3:0]      t_rule;
    typedef logic [1:0]      t_len;
    typedef logic [2:0]      t_status;
    typedef logic [HW-1:0]   t_height;
    typedef logic [AW-1:0]   t_addr;
    typedef logic [2:0][4:0] t_body;

    // terminals
    localparam t_sym SY_ID   = 5'd0;
    localparam t_sym SY_EQ   = 5'd1;
    localparam t_sym SY_ADD  = 5'd2;
    localparam t_sym SY_SUB  = 5'd3;
    localparam t_sym SY_MUL  = 5'd4;
    localparam t_sym SY_DIV  = 5'd5;
    localparam t_sym SY_LP   = 5'd6;
    localparam t_sym SY_RP   = 5'd7;
    localparam t_sym SY_END  = 5'd8;
    // nonterminals
    localparam t_sym SY_S    = 5'd9;
    localparam t_sym SY_E    = 5'd10;
    localparam t_sym SY_EP   = 5'd11;
    localparam t_sym SY_T    = 5'd12;
    localparam t_sym SY_TP   = 5'd13;
    localparam t_sym SY_F    = 5'd14;
    localparam t_sym SY_A    = 5'd15;
    localparam t_sym SY_M    = 5'd16;
    localparam t_sym SY_V    = 5'd17;
    // character that matches nothing
    localparam t_sym SY_NONE = 5'd31;
    localparam t_sym NT_BASE = 5'd9;

    // status codes
    localparam t_status ST_CONSUMED = 3'd0;
    localparam t_status ST_ACCEPTED = 3'd1;
    localparam t_status ST_NO_ENTRY = 3'd2;
    localparam t_status ST_MISMATCH = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;

    // productions
    localparam t_rule R_NONE  = 4'd0;
    localparam t_rule R_S     = 4'd1;
    localparam t_rule R_E     = 4'd2;
    localparam t_rule R_EP    = 4'd3;
    localparam t_rule R_EMPTY = 4'd4;
    localparam t_rule R_T     = 4'd5;
    localparam t_rule R_TP    = 4'd6;
    localparam t_rule R_FPAR  = 4'd7;
    localparam t_rule R_ID    = 4'd8;
    localparam t_rule R_ADD   = 4'd9;
    localparam t_rule R_SUB   = 4'd10;
    localparam t_rule R_MUL   = 4'd11;
    localparam t_rule R_DIV   = 4'd12;

    // queue word from front to back
    typedef struct packed {
        logic valid;
        t_sym tok;
    } t_tok_word;

    // back end status seen by the top level
    typedef struct packed {
        logic    active;
        t_height height;
    } t_back_stat;

    // prediction table: nonterminal on top, lookahead token
    function automatic t_rule predict(input t_sym top, input t_sym tok);
        t_rule r;
        r = R_NONE;
        case (top)
            SY_S: begin
                if (tok == SY_ID) r = R_S;
            end
            SY_E: begin
                if (tok == SY_ID || tok == SY_LP) r = R_E;
            end
            SY_EP: begin
                if (tok == SY_ADD || tok == SY_SUB) r = R_EP;
                else if (tok == SY_RP || tok == SY_END) r = R_EMPTY;
            end
            SY_T: begin
                if (tok == SY_ID || tok == SY_LP) r = R_T;
            end
            SY_TP: begin
                if (tok == SY_MUL || tok == SY_DIV) r = R_TP;
                else if (tok == SY_ADD || tok == SY_SUB || tok == SY_RP || tok == SY_END)
                    r = R_EMPTY;
            end
            SY_F: begin
                if (tok == SY_ID) r = R_ID;
                else if (tok == SY_LP) r = R_FPAR;
            end
            SY_A: begin
                if (tok == SY_ADD) r = R_ADD;
                else if (tok == SY_SUB) r = R_SUB;
            end
            SY_M: begin
                if (tok == SY_MUL) r = R_MUL;
                else if (tok == SY_DIV) r = R_DIV;
            end
            SY_V: begin
                if (tok == SY_ID) r = R_ID;
            end
            default: r = R_NONE;
        endcase
        return r;
    endfunction

    // number of symbols in a production body
    function automatic t_len rule_len(input t_rule r);
        t_len n;
        case (r)
            R_S, R_EP, R_TP, R_FPAR:             n = 2'd3;
            R_E, R_T:                            n = 2'd2;
            R_ID, R_ADD, R_SUB, R_MUL, R_DIV:    n = 2'd1;
            default:                             n = 2'd0;
        endcase
        return n;
    endfunction

    // production body, element 0 ends up on top of the stack
    function automatic t_body rule_body(input t_rule r);
        t_body b;
        b = '0;
        case (r)
            R_S:    b = {SY_E, SY_EQ, SY_V};
            R_E:    b = {5'd0, SY_EP, SY_T};
            R_EP:   b = {SY_EP, SY_T, SY_A};
            R_T:    b = {5'd0, SY_TP, SY_F};
            R_TP:   b = {SY_TP, SY_F, SY_M};
            R_FPAR: b = {SY_RP, SY_E, SY_LP};
            R_ID:   b = {10'd0, SY_ID};
            R_ADD:  b = {10'd0, SY_ADD};
            R_SUB:  b = {10'd0, SY_SUB};
            R_MUL:  b = {10'd0, SY_MUL};
            R_DIV:  b = {10'd0, SY_DIV};
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: src/llp_ram.sv
// generic single write port ram with registered read
`default_nettype none

module llp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/llp_front.sv
// front end: classifies input characters into tokens and queues them
`default_nettype none

module llp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_character,
    input  wire logic              i_end_marker,
    output llp_pkg::t_tok_word     o_word,
    input  wire logic              i_pop
);

    logic [1:0]    r_count;
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    llp_pkg::t_sym r_q_tok [2];
    llp_pkg::t_sym tok;
    logic          push;

    // character to token
    always_comb begin
        if (i_end_marker) begin
            tok = llp_pkg::SY_END;
        end else begin
            case (i_character)
                8'h69:   tok = llp_pkg::SY_ID;
                8'h3d:   tok = llp_pkg::SY_EQ;
                8'h2b:   tok = llp_pkg::SY_ADD;
                8'h2d:   tok = llp_pkg::SY_SUB;
                8'h2a:   tok = llp_pkg::SY_MUL;
                8'h2f:   tok = llp_pkg::SY_DIV;
                8'h28:   tok = llp_pkg::SY_LP;
                8'h29:   tok = llp_pkg::SY_RP;
                default: tok = llp_pkg::SY_NONE;
            endcase
        end
    end

    assign o_s_tready = (r_count != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_word     = '{valid: (r_count != 2'd0), tok: r_q_tok[r_rd_ptr]};

    // two entry token queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_tok[r_wr_ptr] <= tok;
        end
    end

endmodule

`default_nettype wire

// File: src/llp_back.sv
// back end: symbol stack sequencer that expands, pops and matches tokens
`default_nettype none

module llp_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire llp_pkg::t_tok_word  i_word,
    output logic                     o_pop,
    input  wire logic                i_m_tready,
    output logic                     o_m_tvalid,
    output llp_pkg::t_status         o_status,
    output llp_pkg::t_back_stat      o_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_PUSH = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_active, n_active;
    llp_pkg::t_height r_height, n_height;
    llp_pkg::t_sym    r_top, n_top;
    llp_pkg::t_sym    r_tok, n_tok;
    llp_pkg::t_sym    r_pend, n_pend;
    llp_pkg::t_addr   r_pend_addr, n_pend_addr;
    logic             r_cont, n_cont;
    logic             r_out_valid, n_out_valid;
    llp_pkg::t_status r_status, n_status;

    logic             ram_we;
    llp_pkg::t_addr   ram_waddr;
    llp_pkg::t_sym    ram_wdata;
    llp_pkg::t_addr   ram_raddr;
    llp_pkg::t_sym    ram_rdata;

    llp_pkg::t_rule   rule;
    llp_pkg::t_len    len;
    llp_pkg::t_body   body;
    logic [llp_pkg::HW:0] grown;
    llp_pkg::t_height hm1;
    llp_pkg::t_height hm2;
    logic             out_free;

    // symbols below the top of stack
    llp_ram #(
        .WIDTH (5),
        .DEPTH (llp_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // table lookup and stack arithmetic for the current top
    assign rule     = llp_pkg::predict(r_top, r_tok);
    assign len      = llp_pkg::rule_len(rule);
    assign body     = llp_pkg::rule_body(rule);
    assign grown    = {1'b0, r_height} - {{llp_pkg::HW{1'b0}}, 1'b1}
                    + {{(llp_pkg::HW - 1){1'b0}}, len};
    assign hm1      = r_height - llp_pkg::t_height'(1);
    assign hm2      = r_height - llp_pkg::t_height'(2);
    assign out_free = !r_out_valid || i_m_tready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_height    = r_height;
        n_top       = r_top;
        n_tok       = r_tok;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_cont      = r_cont;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        o_pop       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_word.valid) begin
                    o_pop   = 1'b1;
                    n_tok   = i_word.tok;
                    n_state = S_EVAL;
                    // fresh parse: end marker below start symbol
                    if (!r_active) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = llp_pkg::SY_END;
                        n_top     = llp_pkg::SY_S;
                        n_height  = llp_pkg::t_height'(2);
                        n_active  = 1'b1;
                    end
                end
            end
            S_EVAL: begin
                if (r_height == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = llp_pkg::ST_MISMATCH;
                        n_active    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (r_top < llp_pkg::NT_BASE) begin
                    // terminal on top
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        if (r_top == r_tok) begin
                            n_height = hm1;
                            if (r_tok == llp_pkg::SY_END) begin
                                n_status = llp_pkg::ST_ACCEPTED;
                                n_active = 1'b0;
                                n_state  = S_IDLE;
                            end else begin
                                n_status  = llp_pkg::ST_CONSUMED;
                                ram_raddr = hm2[llp_pkg::AW-1:0];
                                n_cont    = 1'b0;
                                n_state   = S_READ;
                            end
                        end else begin
                            n_status = llp_pkg::ST_MISMATCH;
                            n_active = 1'b0;
                            n_state  = S_IDLE;
                        end
                    end
                end else if (rule == llp_pkg::R_NONE) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = llp_pkg::ST_NO_ENTRY;
                        n_active    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (grown > (llp_pkg::HW + 1)'(llp_pkg::STACK_DEPTH)) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = llp_pkg::ST_OVERFLOW;
                        n_active    = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (len == 2'd0) begin
                    // empty production: pop and refetch the top
                    n_height  = hm1;
                    ram_raddr = hm2[llp_pkg::AW-1:0];
                    n_cont    = 1'b1;
                    n_state   = S_READ;
                end else begin
                    // expansion: first body symbol becomes the top
                    n_top    = body[0];
                    n_height = grown[llp_pkg::HW-1:0];
                    if (len != 2'd1) begin
                        ram_we    = 1'b1;
                        ram_waddr = hm1[llp_pkg::AW-1:0];
                        ram_wdata = body[len - 2'd1];
                    end
                    if (len == 2'd3) begin
                        n_pend      = body[1];
                        n_pend_addr = r_height[llp_pkg::AW-1:0];
                        n_state     = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                // middle symbol of a three symbol body
                ram_we    = 1'b1;
                ram_waddr = r_pend_addr;
                ram_wdata = r_pend;
                n_state   = S_EVAL;
            end
            S_READ: begin
                n_top   = ram_rdata;
                n_state = r_cont ? S_EVAL : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_height    <= '0;
            r_cont      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_height    <= n_height;
            r_cont      <= n_cont;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_tok       <= n_tok;
        r_pend      <= n_pend;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_status   = r_status;
    assign o_stat     = '{active: r_active, height: r_height};

endmodule

`default_nettype wire

// File: src/ll1_expression_parser_unit.sv
// LL(1) recognizer for S -> V = E over + - * / and parentheses
// Usage:
//   Slave channel: one word per character. i_s_tdata[7:0] is the character,
//   i_s_tlast marks the end of input (the character is then ignored).
//   Master channel: one word per input word, o_m_tdata[2:0] is the status:
//   0 consumed, 1 accepted, 2 no table entry, 3 terminal mismatch,
//   4 stack overflow. Any status other than consumed ends the parse and the
//   next input word starts a fresh one.
// Structure:
//   a two word token queue sits between the classifier and the stack
//   sequencer. The sequencer takes a token, then expands the top in
//   place (three symbol bodies write the middle symbol in S_PUSH), pops
//   empty productions by reading the new top from the stack ram, and on
//   a consumed match reads the new top before taking the next token; a
//   stalled receiver holds the sequencer at each result.
// Reset: synchronous active low i_rst_n empties the queue, clears the
//   output valid and marks no parse in progress.
// Stall: a result waits in the output register while i_m_tready is low;
//   the sequencer then holds on its next result and the queue fills up
//   before o_s_tready drops.
`default_nettype none

module ll1_expression_parser_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] character
    input  wire logic       i_s_tlast,   // end_marker
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [2:0] status, [7:3] zero
);

    llp_pkg::t_tok_word  word;
    logic                pop;
    llp_pkg::t_status    status;
    llp_pkg::t_back_stat stat;

    // classify and queue
    llp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_character  (i_s_tdata),
        .i_end_marker (i_s_tlast),
        .o_word       (word),
        .i_pop        (pop)
    );

    // parse with the symbol stack
    llp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (word),
        .o_pop      (pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (status),
        .o_stat     (stat)
    );

    assign o_m_tdata = {5'd0, status};

    // stack height stays within the stack
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.height <= llp_pkg::t_height'(llp_pkg::STACK_DEPTH))
        else $error("stack height beyond stack depth");

    // a parse in progress always has its bottom end marker
    a_active_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.active |-> (stat.height != '0))
        else $error("active parse with empty stack");

    // no result word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result word present after reset");

endmodule

`default_nettype wire
